// ===== hdl/screw_forward_reverse_sequencer_core_assert.svh =====
// Assertion macros for the screw forward/reverse sequencer.
`ifndef SCREW_FORWARD_REVERSE_SEQUENCER_CORE_ASSERT_SVH
`define SCREW_FORWARD_REVERSE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SFRS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfrs assertion failed");

// next-cycle implication
`define SFRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfrs assertion failed");

`endif

// ===== hdl/sfrs_pkg.sv =====
// Constants, codes and the chunk size function of the screw sequencer.
package sfrs_pkg;

	localparam int StepW  = 16;
	localparam int ProdW  = 2 * StepW;
	localparam int AddrW  = 3;
	localparam int DataW  = 32;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_CHARGED = 2'd1;
	localparam logic [1:0] PH_FORWARD = 2'd2;
	localparam logic [1:0] PH_REVERSE = 2'd3;

	localparam logic REG_FWD = 1'b0;
	localparam logic REG_REV = 1'b1;

	typedef logic [StepW-1:0] step_t;

	// steps of the forward chunk at idx: min(fwd, goal - idx*fwd), 0 when covered
	function automatic step_t chunk_steps(input step_t idx, input step_t fwd,
			input step_t goal);
		logic [ProdW-1:0] prod;
		step_t            passed;
		step_t            left;
		step_t            res;
		prod   = ProdW'(idx) * ProdW'(fwd);
		passed = prod[StepW-1:0];
		left   = goal - passed;
		if (goal <= passed) begin
			res = '0;
		end else begin
			res = (fwd < left) ? fwd : left;
		end
		return res;
	endfunction

endpackage

// ===== hdl/screw_forward_reverse_sequencer_core.sv =====
// Screw forward/reverse sequencer: goal commands and driver ticks in, move requests out.
//
// channel | direction | handshake           | payload
// in      | in        | in_valid/in_ready   | mode, goal_step_count, driver_busy
// out     | out       | out_valid/out_ready | move_valid, move_clockwise, move_steps, busy_res
// cfg     | in        | APB write/read      | forward_chunk_steps @0, reverse_chunk_steps @4
//
// One word in, one word out; a word is taken every cycle while the result
// register is empty or being drained. The result register behind the single
// multiply/compare/min path presents each result in the cycle after its word is taken.
// After reset the sequencer is idle and both chunk registers are zero.
// A stalled output holds its word and blocks the input until taken.
module screw_forward_reverse_sequencer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  mode,
	input  sfrs_pkg::step_t       goal_step_count,
	input  logic                  driver_busy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  move_valid,
	output logic                  move_clockwise,
	output sfrs_pkg::step_t       move_steps,
	output logic                  busy_res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [sfrs_pkg::AddrW-1:0] paddr,
	input  logic [sfrs_pkg::DataW-1:0] pwdata,
	output logic [sfrs_pkg::DataW-1:0] prdata,
	output logic                  pready
);
	import sfrs_pkg::*;

	step_t      fwd_q;
	step_t      rev_q;
	logic [1:0] phase_q;
	step_t      goal_q;
	step_t      idx_q;
	logic       skip_q;
	logic       out_valid_q;
	logic       move_valid_q;
	logic       move_cw_q;
	step_t      move_steps_q;
	logic       busy_q;

	logic [1:0] phase_d;
	step_t      goal_d;
	step_t      idx_d;
	logic       skip_d;
	logic       issue;
	logic       cw;
	step_t      steps;
	step_t      next_idx;
	step_t      sel_idx;
	step_t      avail;
	logic       in_acc;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_REV) ? DataW'(rev_q) : DataW'(fwd_q);

	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign next_idx = skip_q ? idx_q : idx_q + 1'b1;
	assign sel_idx  = (phase_q == PH_CHARGED) ? idx_q : next_idx;
	assign avail    = chunk_steps(sel_idx, fwd_q, goal_q);

	always_comb begin
		phase_d = phase_q;
		goal_d  = goal_q;
		idx_d   = idx_q;
		skip_d  = skip_q;
		issue   = 1'b0;
		cw      = 1'b0;
		steps   = '0;
		if (mode) begin
			goal_d = goal_step_count;
			idx_d  = '0;
			if (phase_q == PH_IDLE) begin
				phase_d = PH_CHARGED;
			end else if (phase_q inside {PH_FORWARD, PH_REVERSE}) begin
				skip_d = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_CHARGED: begin
					if (avail != '0) begin
						phase_d = PH_FORWARD;
						issue   = 1'b1;
						cw      = 1'b1;
						steps   = avail;
					end else begin
						phase_d = PH_IDLE;
					end
				end
				PH_FORWARD: begin
					if (!driver_busy) begin
						skip_d = 1'b0;
						if (avail != '0 && rev_q != '0) begin
							phase_d = PH_REVERSE;
							issue   = 1'b1;
							steps   = rev_q;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end
				PH_REVERSE: begin
					if (!driver_busy) begin
						skip_d = 1'b0;
						idx_d  = next_idx;
						if (avail != '0) begin
							phase_d = PH_FORWARD;
							issue   = 1'b1;
							cw      = 1'b1;
							steps   = avail;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rev_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FWD) begin
				fwd_q <= pwdata[StepW-1:0];
			end else begin
				rev_q <= pwdata[StepW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			goal_q  <= '0;
			idx_q   <= '0;
			skip_q  <= 1'b0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			goal_q  <= goal_d;
			idx_q   <= idx_d;
			skip_q  <= skip_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			move_valid_q <= issue;
			move_cw_q    <= cw;
			move_steps_q <= steps;
			busy_q       <= (phase_d != PH_IDLE);
		end
	end

	assign out_valid      = out_valid_q;
	assign move_valid     = move_valid_q;
	assign move_clockwise = move_cw_q;
	assign move_steps     = move_steps_q;
	assign busy_res       = busy_q;

`include "screw_forward_reverse_sequencer_core_assert.svh"

	`SFRS_ASSERT_IMPL(a_move_nonzero, out_valid_q && move_valid_q, move_steps_q != '0)
	`SFRS_ASSERT_IMPL(a_no_move_clear, out_valid_q && !move_valid_q,
		move_steps_q == '0 && !move_cw_q)
	`SFRS_ASSERT_IMPL(a_skip_only_moving, phase_q == PH_IDLE || phase_q == PH_CHARGED, !skip_q)
	`SFRS_ASSERT_NEXT(a_busy_tracks_phase, in_acc, busy_q == (phase_q != PH_IDLE))
	`SFRS_ASSERT_NEXT(a_cmd_clears_index, in_acc && mode,
		idx_q == '0 && goal_q == $past(goal_step_count))

endmodule

// ===== tb/sv/tb_screw_forward_reverse_sequencer_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the screw forward/reverse sequencer core.
module tb_screw_forward_reverse_sequencer_core;
	import sfrs_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [AddrW-1:0] FWD_ADDR = AddrW'(4 * REG_FWD);
	localparam logic [AddrW-1:0] REV_ADDR = AddrW'(4 * REG_REV);
	localparam logic MODE_TICK = 1'b0;
	localparam logic MODE_GOAL = 1'b1;

	typedef struct packed {
		logic  mode;
		step_t goal;
		logic  busy;
	} cmd_word_t;

	typedef struct packed {
		logic  valid;
		logic  cw;
		step_t steps;
		logic  busy;
	} move_word_t;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  in_valid        = 1'b0;
	logic                  in_ready;
	logic                  mode            = 1'b0;
	step_t                 goal_step_count = '0;
	logic                  driver_busy     = 1'b0;
	logic                  out_valid;
	logic                  out_ready       = 1'b0;
	logic                  move_valid;
	logic                  move_clockwise;
	step_t                 move_steps;
	logic                  busy_res;
	logic                  psel            = 1'b0;
	logic                  penable         = 1'b0;
	logic                  pwrite          = 1'b0;
	logic [AddrW-1:0]      paddr           = '0;
	logic [DataW-1:0]      pwdata          = '0;
	logic [DataW-1:0]      prdata;
	logic                  pready;

	// sequencer model state and its copy of the chunk registers
	step_t       fwd_chunk = '0;
	step_t       rev_chunk = '0;
	logic [1:0]  seq_phase = PH_IDLE;
	step_t       goal_reg  = '0;
	step_t       chunk_idx = '0;
	logic        skip_inc  = 1'b0;

	cmd_word_t   pending_words[$];
	move_word_t  expected_moves[$];
	move_word_t  head_move;
	int          mismatches    = 0;
	int          cycles        = 0;
	int          hold_cnt      = 0;
	logic        hold_req      = 1'b0;
	logic        sender_steady = 1'b0;
	logic        sink_steady   = 1'b0;

	screw_forward_reverse_sequencer_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.goal_step_count (goal_step_count),
		.driver_busy     (driver_busy),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.move_valid      (move_valid),
		.move_clockwise  (move_clockwise),
		.move_steps      (move_steps),
		.busy_res        (busy_res),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	always #6 clk = ~clk;

	// forward chunk length at a given chunk index, passed steps wrap at 16 bits
	function automatic step_t forward_len(input step_t idx);
		step_t passed;
		step_t left;
		passed = idx * fwd_chunk;
		if (goal_reg <= passed)
			return '0;
		left = goal_reg - passed;
		return (fwd_chunk < left) ? fwd_chunk : left;
	endfunction

	function automatic move_word_t advance_sequencer(input cmd_word_t w);
		move_word_t r;
		step_t      nxt;
		logic       was_fwd;
		r = '0;
		if (w.mode == MODE_GOAL) begin
			goal_reg  = w.goal;
			chunk_idx = '0;
			if (seq_phase == PH_IDLE)
				seq_phase = PH_CHARGED;
			else if (seq_phase == PH_FORWARD || seq_phase == PH_REVERSE)
				skip_inc = 1'b1;
		end else if (seq_phase == PH_CHARGED) begin
			r.steps = forward_len(chunk_idx);
			if (r.steps != '0) begin
				seq_phase = PH_FORWARD;
				r.valid   = 1'b1;
				r.cw      = 1'b1;
			end else begin
				seq_phase = PH_IDLE;
			end
		end else if ((seq_phase == PH_FORWARD || seq_phase == PH_REVERSE) && !w.busy) begin
			was_fwd  = (seq_phase == PH_FORWARD);
			nxt      = skip_inc ? chunk_idx : chunk_idx + 1'b1;
			skip_inc = 1'b0;
			r.steps  = forward_len(nxt);
			if (was_fwd) begin
				if (r.steps != '0)
					r.steps = rev_chunk;
			end else begin
				chunk_idx = nxt;
			end
			if (r.steps == '0) begin
				seq_phase = PH_IDLE;
			end else begin
				r.valid   = 1'b1;
				r.cw      = !was_fwd;
				seq_phase = was_fwd ? PH_REVERSE : PH_FORWARD;
			end
		end
		if (!r.valid) begin
			r.cw    = 1'b0;
			r.steps = '0;
		end
		r.busy = (seq_phase != PH_IDLE);
		return r;
	endfunction

	task automatic queue_word(input logic m, input step_t g, input logic b);
		pending_words.push_back({m, g, b});
	endtask

	task automatic write_reg(input logic [AddrW-1:0] addr, input step_t value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= DataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == FWD_ADDR)
			fwd_chunk = value;
		else
			rev_chunk = value;
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_moves.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// command/tick driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_moves.push_back(
					advance_sequencer({mode, goal_step_count, driver_busy}));
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 &&
						(sender_steady || $urandom_range(0, 99) >= 10)) begin
					{mode, goal_step_count, driver_busy} <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// move request monitor and output back-pressure
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_moves.size() == 0) begin
					$display("%0t: unexpected word valid=%0b cw=%0b steps=%0d busy=%0b",
						$time, move_valid, move_clockwise, move_steps, busy_res);
					mismatches++;
				end else begin
					head_move = expected_moves.pop_front();
					if (move_valid !== head_move.valid) begin
						$display("%0t: move_valid expected %0b actual %0b",
							$time, head_move.valid, move_valid);
						mismatches++;
					end
					if (move_clockwise !== head_move.cw) begin
						$display("%0t: move_clockwise expected %0b actual %0b",
							$time, head_move.cw, move_clockwise);
						mismatches++;
					end
					if (move_steps !== head_move.steps) begin
						$display("%0t: move_steps expected %0d actual %0d",
							$time, head_move.steps, move_steps);
						mismatches++;
					end
					if (busy_res !== head_move.busy) begin
						$display("%0t: busy_res expected %0b actual %0b",
							$time, head_move.busy, busy_res);
						mismatches++;
					end
				end
			end
			if (hold_req) begin
				hold_cnt  <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_cnt > 1) begin
				hold_cnt  <= hold_cnt - 1;
				out_ready <= 1'b0;
			end else begin
				hold_cnt  <= 0;
				out_ready <= sink_steady || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL screw_forward_reverse_sequencer_core");
			$finish;
		end
	end

	initial begin
		step_t fwd_cfg [6];
		step_t rev_cfg [6];
		int    lim;
		int    ticks;
		int    sent;
		step_t goal;
		fwd_cfg = '{16'd1, 16'hFFFF, 16'd7, step_t'($urandom), 16'd0,
			step_t'($urandom_range(1, 40))};
		rev_cfg = '{16'd1, 16'hFFFF, 16'd3, step_t'($urandom),
			step_t'($urandom_range(1, 20)), 16'd0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset chunk sizes: ticks while idle, goals that give a zero chunk
		queue_word(MODE_TICK, 16'hFFFF, 1'b0);
		queue_word(MODE_TICK, 16'h0000, 1'b1);
		queue_word(MODE_GOAL, 16'hFFFF, 1'b1);
		queue_word(MODE_TICK, 16'h0000, 1'b1);
		queue_word(MODE_GOAL, 16'h0000, 1'b0);
		queue_word(MODE_TICK, 16'hFFFF, 1'b0);
		wait_drained();

		// charged reload, busy ticks, new goal mid-move with skipped advance
		write_reg(FWD_ADDR, 16'd5);
		write_reg(REV_ADDR, 16'd2);
		queue_word(MODE_GOAL, 16'd12, 1'b0);
		queue_word(MODE_GOAL, 16'd13, 1'b0);
		queue_word(MODE_TICK, 16'd0, 1'b1);
		queue_word(MODE_TICK, 16'd0, 1'b1);
		queue_word(MODE_TICK, 16'd0, 1'b0);
		queue_word(MODE_TICK, 16'd0, 1'b0);
		queue_word(MODE_GOAL, 16'd20, 1'b1);
		repeat (7) queue_word(MODE_TICK, 16'd0, 1'b0);
		wait_drained();

		// largest chunk, no reverse
		write_reg(FWD_ADDR, 16'hFFFF);
		write_reg(REV_ADDR, 16'd0);
		queue_word(MODE_GOAL, 16'hFFFF, 1'b0);
		queue_word(MODE_TICK, 16'd0, 1'b0);
		queue_word(MODE_TICK, 16'd0, 1'b0);
		wait_drained();

		// steps left but zero reverse chunk ends the run
		write_reg(FWD_ADDR, 16'd3);
		queue_word(MODE_GOAL, 16'd10, 1'b0);
		queue_word(MODE_TICK, 16'd0, 1'b0);
		queue_word(MODE_TICK, 16'd0, 1'b0);

		for (int p = 0; p < 6; p++) begin
			wait_drained();
			write_reg(FWD_ADDR, fwd_cfg[p]);
			write_reg(REV_ADDR, rev_cfg[p]);
			sender_steady <= (p == 1);
			sink_steady   <= (p == 3);
			sent = 0;
			while (sent < 170) begin
				if ($urandom_range(0, 99) < 85) begin
					lim = 6 * fwd_cfg[p];
					if (lim > 65535)
						lim = 65535;
					case ($urandom_range(0, 9))
						0, 1, 2: goal = step_t'($urandom);
						3, 4:    goal = step_t'($urandom_range(0, 3));
						default: goal = step_t'($urandom_range(0, lim));
					endcase
					queue_word(MODE_GOAL, goal, 1'($urandom));
					ticks = $urandom_range(1, 12);
					repeat (ticks)
						queue_word(MODE_TICK, step_t'($urandom), $urandom_range(0, 3) == 0);
					sent += ticks + 1;
				end else begin
					queue_word(1'($urandom), step_t'($urandom), 1'($urandom));
					sent++;
				end
			end
			if (p == 2) begin
				@(posedge clk);
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_moves.size() == 0)
			$display("PASS screw_forward_reverse_sequencer_core");
		else
			$display("FAIL screw_forward_reverse_sequencer_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/sfrs_pkg.sv
hdl/screw_forward_reverse_sequencer_core.sv
tb/sv/tb_screw_forward_reverse_sequencer_core.sv
